// ----- sv/pphd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphd_pkg
// Shared types and constants for the planar pixel HAM decoder.
// ----------------------------------------------------------------------------
package pphd_pkg;

  localparam int CODE_W     = 24;
  localparam int MAX_PLANES = 24;
  localparam int LIMIT_W    = 9;

  // opcodes
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // pixel modes
  localparam logic [1:0] MODE_MAPPED = 2'd0;
  localparam logic [1:0] MODE_HAM    = 2'd1;
  localparam logic [1:0] MODE_DIRECT = 2'd2;

  // HAM control bits (code bits 5:4)
  localparam logic [1:0] HAM_PALETTE = 2'd0;
  localparam logic [1:0] HAM_BLUE    = 2'd1;
  localparam logic [1:0] HAM_RED     = 2'd2;
  localparam logic [1:0] HAM_GREEN   = 2'd3;

  // config register indexes
  localparam logic [1:0] REG_PIXEL_MODE  = 2'd0;
  localparam logic [1:0] REG_MAP_ENTRIES = 2'd1;
  localparam logic [1:0] REG_PLANE_COUNT = 2'd2;

  localparam logic [4:0] PLANE_COUNT_RST = 5'd6;

  typedef struct packed {
    logic        opcode;
    logic [23:0] pixel_code;
    logic [7:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
  } pphd_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] colour_index;
    logic       is_indexed;
    logic       index_out_of_range;
  } pphd_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pphd_rgb_t;

  typedef struct packed {
    logic      load;
    pphd_rgb_t rgb;
  } pphd_held_upd_t;

endpackage

// ----- sv/pphd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pphd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/pphd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphd_decode
// Per-word decode logic: mapped, HAM and direct modes plus held colour update.
// ----------------------------------------------------------------------------
module pphd_decode
  import pphd_pkg::*;
(
  input  pphd_in_t             item,
  input  logic [23:0]          palette_rgb,
  input  pphd_rgb_t            held,
  input  logic [1:0]           pixel_mode,
  input  logic [LIMIT_W-1:0]   limit,
  output logic                 produce,
  output pphd_out_t            result,
  output pphd_held_upd_t       held_upd
);

  logic [7:0] nib2;
  pphd_rgb_t  ham_rgb;

  assign nib2 = {item.pixel_code[3:0], item.pixel_code[3:0]};

  always_comb begin
    ham_rgb = held;
    unique case (item.pixel_code[5:4])
      HAM_PALETTE: ham_rgb = palette_rgb;
      HAM_BLUE:    ham_rgb.blue  = nib2;
      HAM_RED:     ham_rgb.red   = nib2;
      HAM_GREEN:   ham_rgb.green = nib2;
      default:     ham_rgb = held;
    endcase
  end

  always_comb begin
    produce  = (item.opcode == OP_DECODE);
    result   = '0;
    held_upd = '0;
    if (item.opcode == OP_WRITE) begin
      // writing entry 0 also seeds the held colour
      held_upd.load = (item.entry_index == 8'd0);
      held_upd.rgb  = '{red: item.entry_red, green: item.entry_green,
                        blue: item.entry_blue};
    end else begin
      unique case (pixel_mode)
        MODE_HAM: begin
          held_upd.load    = 1'b1;
          held_upd.rgb     = ham_rgb;
          result.out_red   = ham_rgb.red;
          result.out_green = ham_rgb.green;
          result.out_blue  = ham_rgb.blue;
        end
        MODE_DIRECT: begin
          result.out_red   = item.pixel_code[23:16];
          result.out_green = item.pixel_code[15:8];
          result.out_blue  = item.pixel_code[7:0];
        end
        default: begin
          // mapped mode (mode 3 decodes the same way)
          result.colour_index       = item.pixel_code[7:0];
          result.is_indexed         = 1'b1;
          result.index_out_of_range =
            (item.pixel_code >= {{(CODE_W-LIMIT_W){1'b0}}, limit});
        end
      endcase
    end
  end

endmodule

// ----- sv/planar_pixel_ham_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_pixel_ham_decoder_top
// Bitplane pixel code to colour decoder with palette and hold-and-modify.
// ----------------------------------------------------------------------------
// Takes one input word per clock and gives at most one result word per clock
// while out_ready does not stall the output. A word is either a palette write
// (no result) or a pixel code to decode. The pipeline is an input stage, in
// which the palette RAM is read (HAM lookups use entries 0..15) and the code
// is masked to plane_count planes, followed by the decode logic and the
// output register. The held HAM colour is a plain register updated as each
// HAM pixel or entry-0 palette write leaves the input stage, so consecutive
// HAM pixels chain at full rate. Palette entries that were never written read
// back as garbage. Config writes (mode, map size, plane count) are taken at
// any time but are meant to land while the block is idle.
// ----------------------------------------------------------------------------
module planar_pixel_ham_decoder_top
  import pphd_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  // config write channel
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  // input words
  input  logic      in_valid,
  output logic      in_ready,
  input  pphd_in_t  in_data,
  // result words
  output logic      out_valid,
  input  logic      out_ready,
  output pphd_out_t out_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [LIMIT_W-1:0] DEPTH_LIM = LIMIT_W'(PALETTE_DEPTH);

  // config registers
  logic [1:0]         pixel_mode;
  logic [8:0]         map_entries;
  logic [4:0]         plane_count;
  logic [LIMIT_W-1:0] limit;

  // input stage
  logic           s1_valid;
  pphd_in_t       s1_item;
  pphd_in_t       in_masked;
  logic [23:0]    plane_mask;
  logic [4:0]     planes;
  logic [23:0]    palette_rgb;

  // handshake
  logic in_fire;
  logic s1_fire;
  logic out_take;
  logic pal_wr;

  // decode
  pphd_rgb_t      held;
  logic           produce;
  pphd_out_t      result;
  pphd_held_upd_t held_upd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode  <= MODE_MAPPED;
      map_entries <= '0;
      plane_count <= PLANE_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PIXEL_MODE:  pixel_mode  <= cfg_data[1:0];
        REG_MAP_ENTRIES: map_entries <= cfg_data;
        REG_PLANE_COUNT: plane_count <= cfg_data[4:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign limit = (map_entries < DEPTH_LIM) ? map_entries : DEPTH_LIM;

  // clamp plane count, build per-bit mask
  assign planes = (plane_count > 5'(MAX_PLANES)) ? 5'(MAX_PLANES) : plane_count;

  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      plane_mask[i] = (5'(i) < planes);
    end
    in_masked            = in_data;
    in_masked.pixel_code = in_data.pixel_code & plane_mask;
  end

  // pipeline control: output register frees when empty or taken
  assign out_take = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_take;
  assign in_ready = !s1_valid || out_take;
  assign in_fire  = in_valid && in_ready;

  // palette writes beyond the RAM depth are dropped
  assign pal_wr = in_fire && (in_data.opcode == OP_WRITE) &&
                  ({1'b0, in_data.entry_index} < DEPTH_LIM);

  pphd_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_wr),
    .wr_addr (in_data.entry_index[AW-1:0]),
    .wr_data ({in_data.entry_red, in_data.entry_green, in_data.entry_blue}),
    .rd_en   (in_fire),
    .rd_addr (AW'(in_masked.pixel_code[3:0])),
    .rd_data (palette_rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_masked;
    end
  end

  pphd_decode u_decode (
    .item        (s1_item),
    .palette_rgb (palette_rgb),
    .held        (held),
    .pixel_mode  (pixel_mode),
    .limit       (limit),
    .produce     (produce),
    .result      (result),
    .held_upd    (held_upd)
  );

  // held HAM colour
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (s1_fire && held_upd.load) begin
      held <= held_upd.rgb;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_fire && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && produce) begin
      out_data <= result;
    end
  end

endmodule

// ----- sim/tb_planar_pixel_ham_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_pixel_ham_decoder_top
// Self-checking bench for the planar pixel HAM decoder.
// ----------------------------------------------------------------------------
// Loads the low palette entries first, then runs phases under different
// mode / map size / plane count settings. Each phase queues a mix of palette
// writes and pixel codes with random content. Every accepted input word goes
// through a behavioral copy of the decoder (own palette, held colour and
// register copies), and every result word is checked against the oldest
// prediction. Both handshakes get random gaps, and the result side holds off
// for long stretches now and then so that the pipeline backs up.
// ----------------------------------------------------------------------------
module tb_planar_pixel_ham_decoder_top;
  import pphd_pkg::*;

  localparam int PAL_DEPTH       = 256;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int DRAIN_CYCLES    = 6;      // result path is the input stage and output register
  localparam int LONG_HOLD       = 240;    // receiver hold-off, in cycles
  localparam int CYCLE_LIMIT     = 300000;
  // mode code 3 has no name in the package; the block decodes it as mapped
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic      clk;
  logic      rst        = 1'b1;
  logic      cfg_valid  = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = REG_PIXEL_MODE;
  logic [8:0] cfg_data  = '0;
  logic      in_valid   = 1'b0;
  logic      in_ready;
  pphd_in_t  in_data    = '0;
  logic      out_valid;
  logic      out_ready  = 1'b0;
  pphd_out_t out_data;

  planar_pixel_ham_decoder_top #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Decoder mirror: register copies, palette, held HAM colour
  // --------------------------------------------------------------------------
  logic [1:0] mode_now   = MODE_MAPPED;
  logic [8:0] map_now    = '0;
  logic [4:0] planes_now = PLANE_COUNT_RST;
  pphd_rgb_t  pal_mirror [PAL_DEPTH];
  pphd_rgb_t  held_mirror = '0;

  pphd_in_t  pending_words [$];    // words waiting for the driver
  pphd_out_t expected_pixels [$];  // predicted result words, oldest first

  int in_offer_cnt  = 0;
  int in_accept_cnt = 0;
  int results_seen  = 0;
  int fail_count    = 0;
  int cycle_count   = 0;

  // Apply one accepted input word to the mirror; decodes push a prediction.
  function automatic void decode_word(pphd_in_t w);
    pphd_out_t   res;
    int          planes;
    logic [23:0] code;
    logic [8:0]  lim;
    res = '0;
    if (w.opcode == OP_WRITE) begin
      pal_mirror[w.entry_index] = {w.entry_red, w.entry_green, w.entry_blue};
      // entry 0 doubles as the HAM background colour
      if (w.entry_index == 8'd0)
        held_mirror = {w.entry_red, w.entry_green, w.entry_blue};
      return;
    end
    planes = (planes_now > MAX_PLANES) ? MAX_PLANES : int'(planes_now);
    code   = w.pixel_code & (24'hFF_FFFF >> (CODE_W - planes));
    if (mode_now == MODE_HAM) begin
      // only bits 5:4 steer; anything above the six HAM planes is ignored
      case (code[5:4])
        HAM_PALETTE: held_mirror       = pal_mirror[code[3:0]];
        HAM_BLUE:    held_mirror.blue  = {code[3:0], code[3:0]};
        HAM_RED:     held_mirror.red   = {code[3:0], code[3:0]};
        default:     held_mirror.green = {code[3:0], code[3:0]};
      endcase
      res.out_red   = held_mirror.red;
      res.out_green = held_mirror.green;
      res.out_blue  = held_mirror.blue;
    end else if (mode_now == MODE_DIRECT) begin
      res.out_red   = code[23:16];
      res.out_green = code[15:8];
      res.out_blue  = code[7:0];
    end else begin
      // mapped, and the spare mode code too
      lim = (map_now > 9'(PAL_DEPTH)) ? 9'(PAL_DEPTH) : map_now;
      res.colour_index       = code[7:0];
      res.is_indexed         = 1'b1;
      res.index_out_of_range = (code >= 24'(lim));
    end
    expected_pixels.push_back(res);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: input acceptance feeds the mirror, then the result is checked.
  // Prediction comes first so a result that arrives with its input would still line up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pphd_out_t want;
    if (!rst && in_valid && in_ready) begin
      in_accept_cnt++;
      decode_word(in_data);
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", want.out_red, out_data.out_red);
        check_field("out_green", want.out_green, out_data.out_green);
        check_field("out_blue", want.out_blue, out_data.out_blue);
        check_field("colour_index", want.colour_index, out_data.colour_index);
        check_field("is_indexed", 8'(want.is_indexed), 8'(out_data.is_indexed));
        check_field("index_out_of_range", 8'(want.index_out_of_range),
                    8'(out_data.index_out_of_range));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input driver: holds a word until taken, then waits its drawn gap.
  // Gap 0 keeps valid high straight into the next word.
  // --------------------------------------------------------------------------
  int tx_gap    = 0;
  bit tx_steady = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_accept_cnt != in_offer_cnt) begin
      // still waiting for the handshake
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap--;
    end else if (pending_words.size() != 0) begin
      in_data  <= pending_words.pop_front();
      in_valid <= 1'b1;
      in_offer_cnt++;
      if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
      tx_gap = tx_steady ? 0 : $urandom_range(0, 18);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: a drawn stall before each result word; twice in the run
  // it holds off for a long stretch while the driver keeps offering.
  // --------------------------------------------------------------------------
  int rx_counted = 0;
  int rx_wait    = 0;
  bit rx_steady  = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (results_seen != rx_counted) begin
        rx_counted = results_seen;
        if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
        rx_wait = rx_steady ? 0 : $urandom_range(0, 18);
        if (rx_counted % 500 == 250) rx_wait = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PIXEL_MODE:  mode_now   = data[1:0];
      REG_MAP_ENTRIES: map_now    = data;
      REG_PLANE_COUNT: planes_now = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Upper data bits are junk on the narrow registers; the block drops them.
  task automatic set_regs(logic [1:0] mode, logic [8:0] entries, logic [4:0] planes);
    write_reg(REG_PIXEL_MODE, {7'($urandom), mode});
    write_reg(REG_MAP_ENTRIES, entries);
    write_reg(REG_PLANE_COUNT, {4'($urandom), planes});
  endtask

  // Block is idle: queue empty, all taken, all results in, pipeline flushed
  // (trailing palette writes leave no result to wait on).
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_accept_cnt != in_offer_cnt ||
           expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pphd_in_t pixel_word(logic [23:0] code);
    pphd_in_t w;
    w.opcode      = OP_DECODE;
    w.pixel_code  = code;
    w.entry_index = 8'($urandom);   // ignored on a decode
    w.entry_red   = 8'($urandom);
    w.entry_green = 8'($urandom);
    w.entry_blue  = 8'($urandom);
    return w;
  endfunction

  function automatic pphd_in_t palette_word(logic [7:0] idx, pphd_rgb_t rgb);
    pphd_in_t w;
    w.opcode      = OP_WRITE;
    w.pixel_code  = 24'($urandom);  // ignored on a write
    w.entry_index = idx;
    w.entry_red   = rgb.red;
    w.entry_green = rgb.green;
    w.entry_blue  = rgb.blue;
    return w;
  endfunction

  // Random word biased toward the interesting codes for the current setting.
  function automatic pphd_in_t random_word();
    pphd_rgb_t   rgb;
    logic [7:0]  idx;
    logic [23:0] code;
    int          near;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 7))
        0:       rgb = '0;
        1:       rgb = '1;
        default: rgb = 24'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       idx = 8'd0;                       // reloads the held colour
        1, 2:    idx = 8'($urandom_range(0, 15));  // HAM lookup range
        default: idx = 8'($urandom);
      endcase
      return palette_word(idx, rgb);
    end
    case ($urandom_range(0, 7))
      0:       code = '0;
      1:       code = '1;
      2, 3:    code = 24'($urandom_range(0, 63));
      4: begin
        // straddle the map size
        near = int'(map_now) + int'($urandom_range(0, 2)) - 1;
        code = (near < 0) ? '0 : 24'(near);
      end
      default: code = 24'($urandom);
    endcase
    return pixel_word(code);
  endfunction

  task automatic queue_random(int n);
    repeat (n) pending_words.push_back(random_word());
  endtask

  task automatic run_phase(logic [1:0] mode, logic [8:0] entries, logic [4:0] planes);
    set_regs(mode, entries, planes);
    queue_random(ITEMS_PER_PHASE);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load entries 0..15 before any HAM lookup can touch them; entry 0 also
    // sets the held colour.
    for (int k = 0; k < 16; k++)
      pending_words.push_back(palette_word(8'(k),
        {8'(k * 17), 8'(255 - k * 17), {4'(k), ~4'(k)}}));
    pending_words.push_back(palette_word(8'hFF, '1));
    // reset settings: mapped, empty map -> every code flagged
    pending_words.push_back(pixel_word('0));
    pending_words.push_back(pixel_word('1));
    pending_words.push_back(pixel_word(24'h00_0020));
    wait_idle();

    // HAM: each action, palette top entry, and bits above plane 6 dropped
    set_regs(MODE_HAM, 9'd16, 5'd6);
    pending_words.push_back(pixel_word({18'h0, HAM_PALETTE, 4'hF}));
    pending_words.push_back(pixel_word({18'h0, HAM_BLUE, 4'hF}));
    pending_words.push_back(pixel_word({18'h0, HAM_RED, 4'h5}));
    pending_words.push_back(pixel_word({18'h0, HAM_GREEN, 4'hA}));
    pending_words.push_back(pixel_word(24'hFF_FFC0));
    queue_random(ITEMS_PER_PHASE);
    wait_idle();

    run_phase(MODE_DIRECT, 9'd256, 5'd24);
    run_phase(MODE_MAPPED, 9'd256, 5'd24);
    run_phase(MODE_MAPPED, 9'd511, 5'd31);   // map and plane count past range
    run_phase(MODE_SPARE, 9'd100, 5'd8);
    run_phase(MODE_HAM, 9'd0, 5'd4);         // no control bits: lookups only
    run_phase(MODE_HAM, 9'd300, 5'd24);      // wide codes, upper bits ignored
    run_phase(MODE_DIRECT, 9'd1, 5'd0);      // zero planes -> code 0
    run_phase(MODE_HAM, 9'd5, 5'd1);
    run_phase(MODE_MAPPED, 9'd17, 5'd12);
    run_phase(MODE_DIRECT, 9'd0, 5'd31);
    run_phase(MODE_HAM, 9'd255, 5'd25);
    run_phase(MODE_MAPPED, 9'd0, 5'd1);

    repeat (4)
      run_phase(2'($urandom_range(0, 3)), 9'($urandom), 5'($urandom));

    wait_idle();
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
